/* rtl/mwa_pkg.sv */
// ----------------------------------------------------------------------------
// mwa_pkg: shared types and constants
// Widths for the max-weight assignment solver.
// ----------------------------------------------------------------------------
package mwa_pkg;
   localparam int WeightWidth = 16;
   localparam int LabelWidth  = 24;
   localparam int SizeWidth   = 5;

   typedef logic signed [WeightWidth-1:0] weight_type;
   typedef logic signed [LabelWidth-1:0]  label_type;
endpackage

/* rtl/max_weight_assignment.sv */
// ----------------------------------------------------------------------------
// max_weight_assignment: Kuhn-Munkres max-weight perfect assignment
// Loads an n x n weight matrix, solves, then emits one row result per row.
// ----------------------------------------------------------------------------
// Loading: one element per cycle while req_stall is low; after the last element
// the solve runs (a weight read has an address state then a data state; per
// augment every row is scanned and added once and each label update sweeps
// the columns twice), then n result beats, one per cycle while rsp_stall is low.
// Throughput: one solve at a time; req_stall is high during solve/output and
// while a csr write is offered.
// Reset (synchronous, active high): size = 16, load count 0, controller idle.
// ----------------------------------------------------------------------------
module max_weight_assignment #(
   parameter int MAX_SIZE = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  mwa_pkg::weight_type       req_weight,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [3:0]                rsp_row_index,
   output logic [3:0]                rsp_assigned_column,
   output logic                      rsp_final_row,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [mwa_pkg::SizeWidth-1:0] csr_data
);
   import mwa_pkg::*;

   localparam int CAP = (MAX_SIZE < 16) ? MAX_SIZE : 16;
   localparam int IW  = 4;
   localparam int AW  = 8;

   // state codes
   localparam logic [4:0] S_LOAD   = 5'd0;
   localparam logic [4:0] S_INIT   = 5'd1;  // row maxima, label/partner reset
   localparam logic [4:0] S_INITW  = 5'd2;
   localparam logic [4:0] S_PHASE  = 5'd3;  // start of one augment
   localparam logic [4:0] S_ROOTS  = 5'd4;  // slack from root
   localparam logic [4:0] S_ROOTW  = 5'd5;
   localparam logic [4:0] S_POP    = 5'd6;
   localparam logic [4:0] S_SCAN   = 5'd7;  // scan row x, one column per step
   localparam logic [4:0] S_SCANW  = 5'd8;
   localparam logic [4:0] S_ADDR   = 5'd9;  // add_row sweep
   localparam logic [4:0] S_ADDW   = 5'd10;
   localparam logic [4:0] S_DMIN   = 5'd11;
   localparam logic [4:0] S_DAPP   = 5'd12;
   localparam logic [4:0] S_ZSCAN  = 5'd13;
   localparam logic [4:0] S_AUG    = 5'd14;
   localparam logic [4:0] S_OUT    = 5'd15;

   logic [4:0]           state_ff, state_in;
   logic [SizeWidth-1:0] size_ff, size_in;
   logic [8:0]           cnt_ff, cnt_in;
   logic [IW:0]          n_eff;

   // small per-vertex state, each entry at its own fixed place
   label_type            rlab_ff [16], rlab_in [16];
   label_type            clab_ff [16], clab_in [16];
   label_type            slk_ff  [16], slk_in  [16];
   logic [IW:0]          rpart_ff[16], rpart_in[16];
   logic [IW:0]          cpart_ff[16], cpart_in[16];
   logic [IW-1:0]        src_ff  [16], src_in  [16];
   logic [IW-1:0]        par_ff  [16], par_in  [16];
   logic [15:0]          rin_ff, rin_in, cin_ff, cin_in;
   logic [IW-1:0]        q_ff    [16], q_in    [16];
   logic [IW:0]          rd_ff, rd_in, wr_ff, wr_in;
   logic [IW-1:0]        root_ff, root_in, x_ff, x_in, c_ff, c_in;
   logic [IW-1:0]        r_ff, r_in;            // row being added / init row
   logic [IW:0]          matched_ff, matched_in;
   logic [IW-1:0]        px_ff, px_in, py_ff, py_in;
   logic [IW:0]          guard_ff, guard_in;
   label_type            acc_ff, acc_in;        // row max / delta / resume column
   logic                 dvld_ff, dvld_in;
   logic [1:0]           ret_ff, ret_in;        // where add_row returns

   localparam logic [1:0] RET_SCAN = 2'd0;
   localparam logic [1:0] RET_ZERO = 2'd1;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   weight_type           rd_data;
   logic [IW-1:0]        ld_r, ld_c;

   mwa_wmem #(.AW(AW)) u_wmem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_weight),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      if (size_ff == '0) n_eff = 5'd1;
      else if (size_ff > SizeWidth'(CAP)) n_eff = 5'(CAP);
      else n_eff = size_ff;
   end

   // load position from running row/column counters kept in cnt_ff
   assign ld_r = cnt_ff[7:4];
   assign ld_c = cnt_ff[3:0];

   // a pending csr write takes the edge; no weight beat is taken with it
   assign req_stall = (state_ff != S_LOAD) || csr_valid;
   assign csr_ready = (state_ff == S_LOAD);
   assign wr_en     = req_valid && !req_stall;
   assign wr_addr   = {ld_r, ld_c};

   assign rsp_valid           = (state_ff == S_OUT);
   assign rsp_row_index       = r_ff;
   assign rsp_assigned_column = rpart_ff[r_ff][IW] ? 4'd0 : rpart_ff[r_ff][IW-1:0];
   assign rsp_final_row       = ({1'b0, r_ff} == n_eff - 5'd1);

   logic [IW-1:0] nm1;
   assign nm1 = 4'(n_eff - 5'd1);

   label_type wext, red;
   always_comb begin
      wext = LabelWidth'(rd_data);
   end

   always_comb begin
      logic [IW-1:0] cx, ty4;
      logic [IW:0]   ty, p;
      state_in = state_ff; size_in = size_ff; cnt_in = cnt_ff;
      rlab_in = rlab_ff; clab_in = clab_ff; slk_in = slk_ff;
      rpart_in = rpart_ff; cpart_in = cpart_ff; src_in = src_ff; par_in = par_ff;
      rin_in = rin_ff; cin_in = cin_ff; q_in = q_ff; rd_in = rd_ff; wr_in = wr_ff;
      root_in = root_ff; x_in = x_ff; c_in = c_ff; r_in = r_ff;
      matched_in = matched_ff; px_in = px_ff; py_in = py_ff; guard_in = guard_ff;
      acc_in = acc_ff; dvld_in = dvld_ff; ret_in = ret_ff;
      rd_addr = {x_ff, c_ff};
      red = '0; cx = '0; ty = '0; ty4 = '0; p = '0;

      case (state_ff)
         S_LOAD: begin
            if (csr_valid) begin
               size_in = csr_data; cnt_in = '0;
            end else if (wr_en) begin
               if (ld_c == nm1) begin
                  if (ld_r == nm1) begin
                     cnt_in = '0; state_in = S_INIT;
                     r_in = '0; c_in = '0; acc_in = '0;
                  end else begin
                     cnt_in = {1'b0, ld_r + 4'd1, 4'd0};
                  end
               end else begin
                  cnt_in = cnt_ff + 9'd1;
               end
            end
         end
         S_INIT: begin
            rd_addr = {r_ff, c_ff};
            state_in = S_INITW;
         end
         S_INITW: begin
            if (wext > acc_ff) acc_in = wext;
            if (c_ff == nm1) begin
               rlab_in[r_ff] = (wext > acc_ff) ? wext : acc_ff;
               clab_in[r_ff] = '0;
               rpart_in[r_ff] = 5'h10; cpart_in[r_ff] = 5'h10;
               acc_in = '0; c_in = '0;
               if (r_ff == nm1) begin
                  state_in = S_PHASE; matched_in = '0;
               end else begin
                  r_in = r_ff + 4'd1; state_in = S_INIT;
               end
            end else begin
               c_in = c_ff + 4'd1; state_in = S_INIT;
            end
         end
         S_PHASE: begin
            if (matched_ff == n_eff) begin
               state_in = S_OUT; r_in = '0;
            end else begin
               rin_in = '0; cin_in = '0;
               for (int i = 0; i < 16; i++) par_in[i] = '0;
               root_in = '0;
               for (int i = 15; i >= 0; i--)
                  if (5'(i) < n_eff && rpart_ff[i][IW]) root_in = 4'(i);
               q_in[0] = root_in; wr_in = 5'd1; rd_in = '0;
               rin_in[root_in] = 1'b1;
               x_in = root_in; c_in = '0;
               state_in = S_ROOTS;
            end
         end
         S_ROOTS: begin
            state_in = S_ROOTW;
         end
         S_ROOTW: begin
            red = rlab_ff[x_ff] + clab_ff[c_ff] - wext;
            slk_in[c_ff] = red; src_in[c_ff] = x_ff;
            if (c_ff == nm1) state_in = S_POP;
            else begin c_in = c_ff + 4'd1; state_in = S_ROOTS; end
         end
         S_POP: begin
            if (rd_ff < wr_ff) begin
               x_in = q_ff[rd_ff[IW-1:0]]; rd_in = rd_ff + 5'd1;
               c_in = '0; state_in = S_SCAN;
            end else begin
               acc_in = '0; dvld_in = 1'b0; c_in = '0; state_in = S_DMIN;
            end
         end
         S_SCAN: begin
            state_in = S_SCANW;
         end
         S_SCANW: begin
            state_in = S_SCAN;
            if (c_ff == nm1) state_in = S_POP;
            else c_in = c_ff + 4'd1;
            if (wext == rlab_ff[x_ff] + clab_ff[c_ff] && !cin_ff[c_ff]) begin
               p = cpart_ff[c_ff];
               if (p[IW] || p >= n_eff) begin
                  px_in = x_ff; py_in = c_ff; state_in = S_AUG; guard_in = '0;
               end else begin
                  cin_in[c_ff] = 1'b1;
                  if (wr_ff < n_eff) begin
                     q_in[wr_ff[IW-1:0]] = p[IW-1:0]; wr_in = wr_ff + 5'd1;
                  end
                  r_in = p[IW-1:0]; ret_in = RET_SCAN;
                  state_in = S_ADDR;
                  rin_in[p[IW-1:0]] = 1'b1; par_in[p[IW-1:0]] = x_ff;
                  // resume scan after add_row: resume column and last flag are kept in acc
                  if (c_ff == nm1) c_in = c_ff; // flagged below by acc reuse
                  acc_in = {{(LabelWidth-5){1'b0}}, (c_ff == nm1), c_ff};
                  c_in = '0;
               end
            end
         end
         S_ADDR: begin
            rd_addr = {r_ff, c_ff};
            state_in = S_ADDW;
         end
         S_ADDW: begin
            red = rlab_ff[r_ff] + clab_ff[c_ff] - wext;
            if (red < slk_ff[c_ff]) begin
               slk_in[c_ff] = red; src_in[c_ff] = r_ff;
            end
            if (c_ff == nm1) begin
               if (ret_ff == RET_SCAN) begin
                  if (acc_ff[IW]) state_in = S_POP;
                  else begin c_in = acc_ff[IW-1:0] + 4'd1; state_in = S_SCAN; end
               end else begin
                  if (acc_ff[IW]) begin state_in = S_POP; rd_in = '0; end
                  else begin c_in = acc_ff[IW-1:0] + 4'd1; state_in = S_ZSCAN; end
               end
            end else begin
               c_in = c_ff + 4'd1; state_in = S_ADDR;
            end
         end
         S_DMIN: begin
            if (!cin_ff[c_ff] && (!dvld_ff || slk_ff[c_ff] < acc_ff)) begin
               acc_in = slk_ff[c_ff]; dvld_in = 1'b1;
            end
            if (c_ff == nm1) state_in = S_DAPP;
            else c_in = c_ff + 4'd1;
         end
         S_DAPP: begin
            for (int i = 0; i < 16; i++) begin
               if (5'(i) < n_eff) begin
                  if (rin_ff[i]) rlab_in[i] = rlab_ff[i] - acc_ff;
                  if (cin_ff[i]) clab_in[i] = clab_ff[i] + acc_ff;
                  else slk_in[i] = slk_ff[i] - acc_ff;
               end
            end
            rd_in = '0; wr_in = '0; c_in = '0; state_in = S_ZSCAN;
         end
         S_ZSCAN: begin
            if (c_ff == nm1) begin state_in = S_POP; rd_in = '0; end
            else c_in = c_ff + 4'd1;
            if (!cin_ff[c_ff] && slk_ff[c_ff] == '0) begin
               p = cpart_ff[c_ff];
               if (p[IW] || p >= n_eff) begin
                  px_in = src_ff[c_ff]; py_in = c_ff; state_in = S_AUG; guard_in = '0;
               end else begin
                  cin_in[c_ff] = 1'b1;
                  if (!rin_ff[p[IW-1:0]]) begin
                     if (wr_ff < n_eff) begin
                        q_in[wr_ff[IW-1:0]] = p[IW-1:0]; wr_in = wr_ff + 5'd1;
                     end
                     rin_in[p[IW-1:0]] = 1'b1; par_in[p[IW-1:0]] = src_ff[c_ff];
                     r_in = p[IW-1:0]; ret_in = RET_ZERO;
                     acc_in = {{(LabelWidth-5){1'b0}}, (c_ff == nm1), c_ff};
                     c_in = '0; state_in = S_ADDR;
                  end
               end
            end
         end
         S_AUG: begin
            cx = px_ff;
            ty = rpart_ff[cx];
            cpart_in[py_ff] = {1'b0, cx};
            rpart_in[cx] = {1'b0, py_ff};
            guard_in = guard_ff + 5'd1;
            if (cx == root_ff || ty[IW] || ty >= n_eff || guard_ff == n_eff) begin
               matched_in = matched_ff + 5'd1; state_in = S_PHASE;
            end else begin
               ty4 = ty[IW-1:0];
               px_in = par_ff[cx]; py_in = ty4;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               if ({1'b0, r_ff} == n_eff - 5'd1) state_in = S_LOAD;
               else r_in = r_ff + 4'd1;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         size_ff  <= 5'd16;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         cnt_ff   <= cnt_in;
      end
      rlab_ff <= rlab_in; clab_ff <= clab_in; slk_ff <= slk_in;
      rpart_ff <= rpart_in; cpart_ff <= cpart_in; src_ff <= src_in; par_ff <= par_in;
      rin_ff <= rin_in; cin_ff <= cin_in; q_ff <= q_in; rd_ff <= rd_in; wr_ff <= wr_in;
      root_ff <= root_in; x_ff <= x_in; c_ff <= c_in; r_ff <= r_in;
      matched_ff <= matched_in; px_ff <= px_in; py_ff <= py_in; guard_ff <= guard_in;
      acc_ff <= acc_in; dvld_ff <= dvld_in; ret_ff <= ret_in;
   end
endmodule

/* rtl/mwa_wmem.sv */
// ----------------------------------------------------------------------------
// mwa_wmem: weight store
// Synchronous memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mwa_wmem #(
   parameter int AW = 8
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  mwa_pkg::weight_type    wr_data,
   input  logic [AW-1:0]          rd_addr,
   output mwa_pkg::weight_type    rd_data
);
   import mwa_pkg::*;
   weight_type mem [2**AW];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/mwa_checker.sv */
// ----------------------------------------------------------------------------
// mwa_checker: port-level checks
// Watches the top level's ports and is bound to it.
// ----------------------------------------------------------------------------
module mwa_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_row_index,
   input logic       rsp_final_row,
   input logic       csr_ready
);
   // no input taken while results go out
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input open during output");
   // config only while loading
   a_cfg: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !rsp_valid) else $error("config open during output");
   // rows advance by one after a taken beat that is not last
   a_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_final_row |=>
      rsp_valid && rsp_row_index == $past(rsp_row_index) + 4'd1)
      else $error("row order");
   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_row_index))
      else $error("result dropped");
endmodule

bind max_weight_assignment mwa_checker u_mwa_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_row_index(rsp_row_index),
   .rsp_final_row(rsp_final_row), .csr_ready(csr_ready)
);

/* sim/tb_max_weight_assignment.sv */
// ----------------------------------------------------------------------------
// tb_max_weight_assignment: regression for the max-weight assignment solver
// Streams weight matrices in, predicts each row assignment with an in-bench
// Kuhn-Munkres model and checks every result beat against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_max_weight_assignment;
   import mwa_pkg::*;

   localparam int MaxSize    = 16;
   localparam int NoPartner  = -1;
   localparam int CycleLimit = 3000000;

   typedef struct packed {
      logic [3:0] row_index;
      logic [3:0] assigned_column;
      logic       final_row;
   } row_result_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   weight_type           req_weight = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [3:0]           rsp_row_index;
   logic [3:0]           rsp_assigned_column;
   logic                 rsp_final_row;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [SizeWidth-1:0] csr_data = '0;

   max_weight_assignment #(.MAX_SIZE(MaxSize)) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_weight          (req_weight),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_row_index       (rsp_row_index),
      .rsp_assigned_column (rsp_assigned_column),
      .rsp_final_row       (rsp_final_row),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---- predictor state --------------------------------------------------
   logic signed [15:0] mat_weight [MaxSize*MaxSize];
   int                 mat_fill;
   logic [4:0]         size_reg;
   longint             lbl_row [MaxSize];
   longint             lbl_col [MaxSize];
   int                 mate_row [MaxSize];
   int                 mate_col [MaxSize];
   longint             slack [MaxSize];
   int                 slack_row [MaxSize];
   int                 parent [MaxSize];
   bit                 in_row [MaxSize];
   bit                 in_col [MaxSize];
   int                 bfs_q [MaxSize];

   row_result_t        expected_rows [$];
   int                 fail_count = 0;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   int                 hold_cycles = 0;   // long receiver hold-off when > 0

   function automatic int size_in_use();
      int n;
      n = size_reg;
      if (n < 1) n = 1;
      if (n > MaxSize) n = MaxSize;
      return n;
   endfunction

   function automatic longint w_at(int r, int c);
      return longint'(mat_weight[r*MaxSize + c]);
   endfunction

   function automatic void grow_tree(int r, int par, int n);
      longint s;
      in_row[r] = 1'b1;
      parent[r] = par;
      for (int c = 0; c < n; c++) begin
         s = lbl_row[r] + lbl_col[c] - w_at(r, c);
         if (s < slack[c]) begin
            slack[c] = s;
            slack_row[c] = r;
         end
      end
   endfunction

   // Hungarian method with the same scan order and tie breaking as the block
   function automatic void solve_assignment(int n);
      int     rd, wr, root, px, py, x, p, cx, cy, ty;
      bit     found;
      longint m, delta;
      for (int r = 0; r < n; r++) begin
         m = 0;
         for (int c = 0; c < n; c++) if (w_at(r, c) > m) m = w_at(r, c);
         lbl_row[r] = m;
         lbl_col[r] = 0;
         mate_row[r] = NoPartner;
         mate_col[r] = NoPartner;
      end
      for (int k = 0; k < n; k++) begin
         rd = 0; wr = 0; root = 0; px = 0; py = 0; found = 0;
         for (int i = 0; i < n; i++) begin
            in_row[i] = 0; in_col[i] = 0; parent[i] = 0;
         end
         for (int r = 0; r < n; r++)
            if (mate_row[r] == NoPartner) begin
               root = r;
               break;
            end
         bfs_q[wr] = root;
         wr++;
         in_row[root] = 1'b1;
         for (int c = 0; c < n; c++) begin
            slack[c] = lbl_row[root] + lbl_col[c] - w_at(root, c);
            slack_row[c] = root;
         end
         while (!found) begin
            while (rd < wr && !found) begin
               x = bfs_q[rd];
               rd++;
               for (int c = 0; c < n; c++) begin
                  if (w_at(x, c) == lbl_row[x] + lbl_col[c] && !in_col[c]) begin
                     p = mate_col[c];
                     if (p < 0 || p >= n) begin
                        found = 1; px = x; py = c;
                        break;
                     end
                     in_col[c] = 1'b1;
                     if (wr < n) begin
                        bfs_q[wr] = p;
                        wr++;
                     end
                     grow_tree(p, x, n);
                  end
               end
            end
            if (found) break;
            delta = 64'h7fff_ffff_ffff_ffff;
            for (int c = 0; c < n; c++)
               if (!in_col[c] && slack[c] < delta) delta = slack[c];
            for (int r = 0; r < n; r++) if (in_row[r]) lbl_row[r] -= delta;
            for (int c = 0; c < n; c++) begin
               if (in_col[c]) lbl_col[c] += delta;
               else slack[c] -= delta;
            end
            rd = 0; wr = 0;
            for (int c = 0; c < n; c++) begin
               if (!in_col[c] && slack[c] == 0) begin
                  p = mate_col[c];
                  if (p < 0 || p >= n) begin
                     px = slack_row[c]; py = c; found = 1;
                     break;
                  end
                  in_col[c] = 1'b1;
                  if (!in_row[p]) begin
                     if (wr < n) begin
                        bfs_q[wr] = p;
                        wr++;
                     end
                     grow_tree(p, slack_row[c], n);
                  end
               end
            end
         end
         cx = px; cy = py;
         for (int g = 0; g <= n; g++) begin
            ty = mate_row[cx];
            mate_col[cy] = cx;
            mate_row[cx] = cy;
            if (cx == root) break;
            cx = parent[cx];
            if (ty < 0 || ty >= n) break;
            cy = ty;
         end
      end
   endfunction

   // Store one accepted weight; on the last element queue the row results.
   function automatic void predict_weight(logic signed [15:0] w);
      int n;
      row_result_t res;
      n = size_in_use();
      if (mat_fill >= n*n) mat_fill = 0;
      mat_weight[(mat_fill / n)*MaxSize + (mat_fill % n)] = w;
      mat_fill++;
      if (mat_fill < n*n) return;
      mat_fill = 0;
      solve_assignment(n);
      for (int r = 0; r < n; r++) begin
         res.row_index       = 4'(r);
         res.assigned_column = 4'(mate_row[r] < 0 ? 0 : mate_row[r]);
         res.final_row       = (r == n-1);
         expected_rows = {expected_rows, res};
      end
   endfunction

   // ---- stimulus helpers -------------------------------------------------
   // valid stays up after a beat when the next one follows at once
   task automatic send_weight(logic signed [15:0] w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_weight <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_weight(w);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rows.size() != 0) @(negedge clock);
   endtask

   task automatic write_size(logic [4:0] sz);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= sz;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      size_reg = sz;
      mat_fill = 0;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random weight: mostly small values to provoke ties, some full range
   function automatic logic signed [15:0] rand_weight();
      case ($urandom_range(3))
         0:       return 16'($urandom);
         1:       return 16'($urandom_range(7)) - 16'sd3;
         2:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         default: return 16'($urandom_range(200)) - 16'sd100;
      endcase
   endfunction

   task automatic send_matrix(int n);
      for (int i = 0; i < n*n; i++) send_weight(rand_weight());
   endtask

   // ---- receiver and checker ---------------------------------------------
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      row_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rows.size() == 0) begin
            $display("%0t: unexpected result beat row %0d col %0d last %0b",
                     $realtime, rsp_row_index, rsp_assigned_column, rsp_final_row);
            fail_count++;
         end else begin
            want = expected_rows.pop_front();
            if (rsp_row_index !== want.row_index) begin
               $display("%0t: row_index expected %0d actual %0d",
                        $realtime, want.row_index, rsp_row_index);
               fail_count++;
            end
            if (rsp_assigned_column !== want.assigned_column) begin
               $display("%0t: assigned_column (row %0d) expected %0d actual %0d",
                        $realtime, want.row_index, want.assigned_column,
                        rsp_assigned_column);
               fail_count++;
            end
            if (rsp_final_row !== want.final_row) begin
               $display("%0t: final_row expected %0b actual %0b",
                        $realtime, want.final_row, rsp_final_row);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("max_weight_assignment regression: fail");
         $finish;
      end
   end

   // ---- tests ------------------------------------------------------------
   // Directed small cases: 1x1, all negative rows, ties, size 0 and partial drop.
   task automatic test_directed();
      write_size(5'd1);
      send_weight(16'sh8000);
      send_weight(16'sh7fff);
      write_size(5'd0);           // acts as a size of one
      send_weight(16'sd0);
      write_size(5'd2);
      send_weight(-16'sd5); send_weight(-16'sd1);   // all negative: label floors at 0
      send_weight(-16'sd2); send_weight(-16'sd9);
      send_weight(16'sd4); send_weight(16'sd4);     // full tie
      send_weight(16'sd4); send_weight(16'sd4);
      write_size(5'd3);
      send_weight(16'sd1); send_weight(16'sd2);      // dropped by the next write
      write_size(5'd3);
      for (int i = 0; i < 9; i++) send_weight(16'(i % 3 == 0 ? 16'sh7fff : 16'sh0001));
   endtask

   // Long receiver hold-off: the second matrix waits behind the stalled output.
   task automatic test_hold();
      write_size(5'd5);
      hold_cycles = 3000;
      send_matrix(5);
      send_matrix(5);
      wait_drained();             // sender pauses until every result is back
   endtask

   task automatic test_random(int items);
      int sent, n;
      sent = 0;
      while (sent < items) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(8, 7) : $urandom_range(6, 1);
         write_size(5'(n));
         send_matrix(n);
         sent += n*n;
      end
   endtask

   initial begin
      size_reg = 5'd16;
      mat_fill = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 34; recv_idle_pct = 67;
      test_directed();
      test_random(45);

      send_idle_pct = 67; recv_idle_pct = 34;
      test_hold();
      test_random(45);

      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(45);

      wait_drained();
      repeat (200) @(negedge clock);
      if (fail_count == 0 && expected_rows.size() == 0) begin
         $display("max_weight_assignment regression: pass");
      end else begin
         $display("max_weight_assignment regression: fail");
      end
      $finish;
   end
endmodule
